// ----- rtl/core/circle_raster_canvas_macros.svh -----
// Assertion macros shared by the circle raster canvas RTL.
`ifndef CIRCLE_RASTER_CANVAS_MACROS_SVH
`define CIRCLE_RASTER_CANVAS_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define CRCV_ASSERT_SAME(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (expr)) \
      else $error("crcv: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define CRCV_ASSERT_NEXT(label, clk, rst, cond, expr) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (expr)) \
      else $error("crcv: next-cycle check failed");

`endif

// ----- rtl/core/crcv_pkg.sv -----
// Shared constants and types for the circle raster canvas.
`default_nettype none

package crcv_pkg;

   localparam int MAX_SIDE_DEF  = 256;
   localparam int FRAC_BITS_DEF = 8;

   localparam int CMD_W      = 2;
   localparam int COORD_W    = 19;
   localparam int CHAR_W     = 8;
   localparam int PIX_W      = 8;
   localparam int STATUS_W   = 2;
   localparam int SIDE_CFG_W = 9;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 9;

   localparam logic [CHAR_W-1:0]     SHAPE_RING   = 8'h63;  // 'c'
   localparam logic [CHAR_W-1:0]     SHAPE_DISC   = 8'h43;  // 'C'
   localparam logic [SIDE_CFG_W-1:0] SIDE_RESET   = 9'd256;
   localparam logic [CHAR_W-1:0]     BG_RESET     = 8'd32;

   typedef enum logic [CMD_W-1:0] {
      CMD_DRAW  = 2'd0,
      CMD_READ  = 2'd1,
      CMD_CLEAR = 2'd2,
      CMD_NONE  = 2'd3
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK      = 2'd0,
      STAT_REJECT  = 2'd1,
      STAT_OUTSIDE = 2'd2
   } status_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_HEIGHT = 2'd1,
      CSR_BG     = 2'd2
   } csr_type;

endpackage

`default_nettype wire

// ----- rtl/core/crcv_ram.sv -----
// Single-port synchronous RAM with registered read data.
`default_nettype none

module crcv_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    addr,
   input  wire logic [WIDTH-1:0] wdata,
   output logic      [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

`default_nettype wire

// ----- rtl/core/circle_raster_canvas.sv -----
// Top level: character canvas in RAM with clear, circle draw and pixel read.
//
//  channel   handshake               payload
//  request   start / busy            req_cmd .. req_pixel_row
//  result    rsp_valid (strobe)      rsp_status, rsp_pixel_char
//  config    csr_valid / csr_ready   csr_index, csr_wdata
//
// Draw and clear sweep the canvas one pixel per cycle through the single RAM
// port; an empty canvas skips the sweep. A read goes through the registered RAM
// read; a reject and the unused command go straight to the result.
// Reset is synchronous and restores the canvas size and background byte; the
// canvas contents are not cleared. busy stays high until the result is issued.
// The receiver cannot stall: each result is shown for exactly one cycle.
`default_nettype none

module circle_raster_canvas
   import crcv_pkg::*;
#(
   parameter int MAX_SIDE  = MAX_SIDE_DEF,
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   output logic                           busy,
   input  wire logic        [CMD_W-1:0]   req_cmd,
   input  wire logic        [CHAR_W-1:0]  req_shape_kind,
   input  wire logic signed [COORD_W-1:0] req_center_x,
   input  wire logic signed [COORD_W-1:0] req_center_y,
   input  wire logic signed [COORD_W-1:0] req_radius,
   input  wire logic        [CHAR_W-1:0]  req_paint_char,
   input  wire logic        [PIX_W-1:0]   req_pixel_col,
   input  wire logic        [PIX_W-1:0]   req_pixel_row,
   output logic                           rsp_valid,
   output logic             [STATUS_W-1:0] rsp_status,
   output logic             [CHAR_W-1:0]  rsp_pixel_char,
   input  wire logic                      csr_valid,
   output logic                           csr_ready,
   input  wire logic        [CSR_IDX_W-1:0]  csr_index,
   input  wire logic        [CSR_DATA_W-1:0] csr_wdata
);

`include "circle_raster_canvas_macros.svh"

   localparam int IW    = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int DEPTH = MAX_SIDE * MAX_SIDE;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int SW    = $clog2(MAX_SIDE + 1);
   localparam int EW    = (SW > SIDE_CFG_W) ? SW : SIDE_CFG_W;
   localparam int PW    = IW + FRAC_BITS;
   localparam int DW    = ((PW > COORD_W) ? PW : COORD_W) + 2;
   localparam int Q2W   = 2 * DW;
   localparam int RW    = COORD_W + 1;

   localparam logic signed [DW-1:0] ONE_D   = DW'(1 << FRAC_BITS);
   localparam logic signed [RW-1:0] ONE_R   = RW'(1 << FRAC_BITS);
   localparam logic [Q2W-1:0]       ONE_SQ  = Q2W'(1) << (2 * FRAC_BITS);
   localparam logic [EW-1:0]        SIDE_MAX = EW'(MAX_SIDE);
   localparam logic [AW-1:0]        ROW_STEP = AW'(MAX_SIDE);

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SETUP = 6'b000010,
      ST_WALK  = 6'b000100,
      ST_DRAIN = 6'b001000,
      ST_READ  = 6'b010000,
      ST_RESP  = 6'b100000
   } state_type;

   // control
   state_type               state_ff, state_in;
   logic                    p_valid_ff, p_valid_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [SIDE_CFG_W-1:0]   width_cfg_ff, width_cfg_in;
   logic [SIDE_CFG_W-1:0]   height_cfg_ff, height_cfg_in;
   logic [CHAR_W-1:0]       bg_ff, bg_in;

   // payload
   logic signed [COORD_W-1:0] cx_ff, cx_in, cy_ff, cy_in, r_ff, r_in;
   logic [CHAR_W-1:0]       paint_ff, paint_in;
   logic                    fill_ff, fill_in;
   logic                    ring_ff, ring_in;
   logic                    rd_ok_ff, rd_ok_in;
   status_type              status_ff, status_in;
   logic [AW-1:0]           rd_addr_ff, rd_addr_in;
   logic [Q2W-1:0]          r2_ff, r2_in, inner2_ff, inner2_in;
   logic                    inner_neg_ff, inner_neg_in;
   logic [Q2W-1:0]          cx2_ff, cx2_in;
   logic signed [DW-1:0]    dx_ff, dx_in, dy_ff, dy_in;
   logic [Q2W-1:0]          dx2_ff, dx2_in, dy2_ff, dy2_in;
   logic [IW-1:0]           col_ff, col_in, row_ff, row_in;
   logic [AW-1:0]           addr_ff, addr_in, row_base_ff, row_base_in;
   logic [Q2W:0]            p_d2_ff, p_d2_in;
   logic [AW-1:0]           p_addr_ff, p_addr_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [CHAR_W-1:0]       rsp_char_ff, rsp_char_in;

   // combinational helpers
   logic [EW-1:0]             wide_w, wide_h, used_w, used_h;
   logic                      accept, empty, reject, outside, last_col, last_row, hit;
   logic                      sweep, rsp_err;
   logic signed [2*COORD_W-1:0] cx_sq, cy_sq, r_sq;
   logic signed [RW-1:0]      inner;
   logic signed [2*RW-1:0]    inner_sq;
   logic signed [DW-1:0]      neg_cx, neg_cy;
   logic [Q2W-1:0]            dx_inc, dy_inc;
   logic                      ram_we;
   logic [AW-1:0]             ram_addr;
   logic [CHAR_W-1:0]         ram_wdata, ram_rdata;

   assign wide_w = EW'(width_cfg_ff);
   assign wide_h = EW'(height_cfg_ff);
   assign used_w = (wide_w > SIDE_MAX) ? SIDE_MAX : wide_w;
   assign used_h = (wide_h > SIDE_MAX) ? SIDE_MAX : wide_h;
   assign empty  = (used_w == '0) || (used_h == '0);

   assign busy      = (state_ff != ST_IDLE);
   assign accept    = start && !busy;
   assign csr_ready = 1'b1;

   assign reject  = (req_radius <= $signed(COORD_W'(0))) ||
                    ((req_shape_kind != SHAPE_RING) && (req_shape_kind != SHAPE_DISC));
   assign outside = (EW'(req_pixel_col) >= used_w) || (EW'(req_pixel_row) >= used_h);

   // setup products, one multiplier each, registered
   assign cx_sq    = cx_ff * cx_ff;
   assign cy_sq    = cy_ff * cy_ff;
   assign r_sq     = r_ff * r_ff;
   assign inner    = RW'(r_ff) - ONE_R;
   assign inner_sq = inner * inner;
   assign neg_cx   = -DW'(cx_ff);
   assign neg_cy   = -DW'(cy_ff);

   // (d + one)^2 = d^2 + 2*one*d + one^2
   assign dx_inc = (Q2W'(dx_ff) << (FRAC_BITS + 1)) + ONE_SQ;
   assign dy_inc = (Q2W'(dy_ff) << (FRAC_BITS + 1)) + ONE_SQ;

   assign last_col = (EW'(col_ff) == used_w - EW'(1));
   assign last_row = (EW'(row_ff) == used_h - EW'(1));

   // paint stage: squared distance against squared radius and inner radius
   assign hit = (p_d2_ff <= (Q2W + 1)'(r2_ff)) &&
                (!ring_ff || inner_neg_ff || (p_d2_ff > (Q2W + 1)'(inner2_ff)));

   assign ram_we    = p_valid_ff && (fill_ff || hit);
   assign ram_wdata = fill_ff ? bg_ff : paint_ff;
   assign ram_addr  = p_valid_ff ? p_addr_ff : rd_addr_ff;

   assign sweep   = (state_ff == ST_WALK) || (state_ff == ST_DRAIN);
   assign rsp_err = rsp_valid && (rsp_status != STAT_OK);

   crcv_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (DEPTH)
   ) u_canvas (
      .clock (clock),
      .we    (ram_we),
      .addr  (ram_addr),
      .wdata (ram_wdata),
      .rdata (ram_rdata)
   );

   always_comb begin
      width_cfg_in  = width_cfg_ff;
      height_cfg_in = height_cfg_ff;
      bg_in         = bg_ff;
      if (csr_valid && csr_ready) begin
         case (csr_type'(csr_index))
            CSR_WIDTH:  width_cfg_in  = csr_wdata;
            CSR_HEIGHT: height_cfg_in = csr_wdata;
            CSR_BG:     bg_in         = csr_wdata[CHAR_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      state_in     = state_ff;
      cx_in        = cx_ff;
      cy_in        = cy_ff;
      r_in         = r_ff;
      paint_in     = paint_ff;
      fill_in      = fill_ff;
      ring_in      = ring_ff;
      rd_ok_in     = rd_ok_ff;
      status_in    = status_ff;
      rd_addr_in   = rd_addr_ff;
      r2_in        = r2_ff;
      inner2_in    = inner2_ff;
      inner_neg_in = inner_neg_ff;
      cx2_in       = cx2_ff;
      dx_in        = dx_ff;
      dy_in        = dy_ff;
      dx2_in       = dx2_ff;
      dy2_in       = dy2_ff;
      col_in       = col_ff;
      row_in       = row_ff;
      addr_in      = addr_ff;
      row_base_in  = row_base_ff;
      p_valid_in   = 1'b0;
      p_d2_in      = {1'b0, dx2_ff} + {1'b0, dy2_ff};
      p_addr_in    = addr_ff;
      rsp_valid_in = 1'b0;
      rsp_status_in = status_ff;
      rsp_char_in  = '0;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cx_in      = req_center_x;
               cy_in      = req_center_y;
               r_in       = req_radius;
               paint_in   = req_paint_char;
               ring_in    = (req_shape_kind == SHAPE_RING);
               fill_in    = 1'b0;
               rd_ok_in   = 1'b0;
               status_in  = STAT_OK;
               rd_addr_in = AW'(req_pixel_row) * ROW_STEP + AW'(req_pixel_col);
               case (cmd_type'(req_cmd))
                  CMD_DRAW: begin
                     if (reject) begin
                        status_in = STAT_REJECT;
                        state_in  = ST_RESP;
                     end else begin
                        state_in  = ST_SETUP;
                     end
                  end
                  CMD_READ: begin
                     if (outside) begin
                        status_in = STAT_OUTSIDE;
                        state_in  = ST_RESP;
                     end else begin
                        rd_ok_in  = 1'b1;
                        state_in  = ST_READ;
                     end
                  end
                  CMD_CLEAR: begin
                     fill_in  = 1'b1;
                     state_in = ST_SETUP;
                  end
                  default: begin
                     state_in = ST_RESP;
                  end
               endcase
            end
         end
         ST_SETUP: begin
            r2_in        = Q2W'(r_sq);
            inner2_in    = Q2W'(inner_sq);
            inner_neg_in = inner[RW-1];
            cx2_in       = Q2W'(cx_sq);
            dx2_in       = Q2W'(cx_sq);
            dy2_in       = Q2W'(cy_sq);
            dx_in        = neg_cx;
            dy_in        = neg_cy;
            col_in       = '0;
            row_in       = '0;
            addr_in      = '0;
            row_base_in  = '0;
            state_in     = empty ? ST_RESP : ST_WALK;
         end
         ST_WALK: begin
            p_valid_in = 1'b1;
            if (last_col) begin
               col_in      = '0;
               dx_in       = neg_cx;
               dx2_in      = cx2_ff;
               row_in      = row_ff + IW'(1);
               dy_in       = dy_ff + ONE_D;
               dy2_in      = dy2_ff + dy_inc;
               addr_in     = row_base_ff + ROW_STEP;
               row_base_in = row_base_ff + ROW_STEP;
               if (last_row) begin
                  state_in = ST_DRAIN;
               end
            end else begin
               col_in  = col_ff + IW'(1);
               dx_in   = dx_ff + ONE_D;
               dx2_in  = dx2_ff + dx_inc;
               addr_in = addr_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESP;
         end
         ST_READ: begin
            state_in = ST_RESP;
         end
         ST_RESP: begin
            rsp_valid_in  = 1'b1;
            rsp_status_in = status_ff;
            rsp_char_in   = rd_ok_ff ? ram_rdata : '0;
            state_in      = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         p_valid_ff    <= 1'b0;
         rsp_valid_ff  <= 1'b0;
         width_cfg_ff  <= SIDE_RESET;
         height_cfg_ff <= SIDE_RESET;
         bg_ff         <= BG_RESET;
      end else begin
         state_ff      <= state_in;
         p_valid_ff    <= p_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
         width_cfg_ff  <= width_cfg_in;
         height_cfg_ff <= height_cfg_in;
         bg_ff         <= bg_in;
      end
   end

   always_ff @(posedge clock) begin
      cx_ff         <= cx_in;
      cy_ff         <= cy_in;
      r_ff          <= r_in;
      paint_ff      <= paint_in;
      fill_ff       <= fill_in;
      ring_ff       <= ring_in;
      rd_ok_ff      <= rd_ok_in;
      status_ff     <= status_in;
      rd_addr_ff    <= rd_addr_in;
      r2_ff         <= r2_in;
      inner2_ff     <= inner2_in;
      inner_neg_ff  <= inner_neg_in;
      cx2_ff        <= cx2_in;
      dx_ff         <= dx_in;
      dy_ff         <= dy_in;
      dx2_ff        <= dx2_in;
      dy2_ff        <= dy2_in;
      col_ff        <= col_in;
      row_ff        <= row_in;
      addr_ff       <= addr_in;
      row_base_ff   <= row_base_in;
      p_d2_ff       <= p_d2_in;
      p_addr_ff     <= p_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_char_ff   <= rsp_char_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_pixel_char = rsp_char_ff;

   `CRCV_ASSERT_NEXT(a_strobe_single, clock, reset, rsp_valid, !rsp_valid)
   `CRCV_ASSERT_NEXT(a_accept_busy, clock, reset, start && !busy, busy)
   `CRCV_ASSERT_SAME(a_write_in_sweep, clock, reset, ram_we, sweep)
   `CRCV_ASSERT_SAME(a_char_zero, clock, reset, rsp_err, rsp_pixel_char == '0)

endmodule

`default_nettype wire
